[design/mdpa_pkg.sv]
// Shared types for the modular dot-product accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package mdpa_pkg;

   // Entries in the term queue and in the result queue.
   localparam int QUEUE_DEPTH = 2;

   // Engine sequencer states, one-hot.
   typedef enum logic [3:0] {
      ENG_IDLE     = 4'b0001,
      ENG_REDUCE   = 4'b0010,
      ENG_MULTIPLY = 4'b0100,
      ENG_FINISH   = 4'b1000
   } engine_state_type;

   // Control side of the term hand-off from front to engine.
   typedef struct packed {
      logic valid;
      logic last_term;
   } term_ctl_type;

endpackage

`default_nettype wire

[design/modular_dot_product_accumulator.sv]
// Top level of the modular dot-product accumulator: modulus register,
// front-end term queue and back-end engine. Depends on mdpa_pkg,
// mdpa_front and mdpa_engine.
//
//   Channel   Handshake         Payload
//   req       push / full       matrix_entry, vector_entry, last_term
//   rsp       pop / empty       dot_value
//   csr       write             modulus
//
// Each term passes through the engine in four steps: a load, a reduction of the
// operand and running sum one bit at a time, the bit-serial double-and-add
// multiply, and an accumulate.
// A two-entry term queue lets requests arrive while the engine is busy.
// A last term waits in the engine only while the two-entry result queue is full.
// Reset is synchronous; it empties both queues, clears the sum, sets modulus 2.
`default_nettype none

module modular_dot_product_accumulator #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [WORD_BITS-1:0]   req_matrix_entry,
   input  wire logic [WORD_BITS-1:0]   req_vector_entry,
   input  wire logic                   req_last_term,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [WORD_BITS-1:0]        rsp_dot_value,
   input  wire logic                   csr_write,
   input  wire logic [WORD_BITS-1:0]   csr_modulus
);
   import mdpa_pkg::*;

   logic [WORD_BITS-1:0] modulus_ff;
   term_ctl_type         term_ctl;
   logic [WORD_BITS-1:0] term_matrix, term_vector;
   logic                 term_take;

   // Modulus register.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WORD_BITS'(2);
      end else if (csr_write) begin
         modulus_ff <= csr_modulus;
      end
   end

   mdpa_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_matrix_entry (req_matrix_entry),
      .req_vector_entry (req_vector_entry),
      .req_last_term    (req_last_term),
      .term_ctl         (term_ctl),
      .term_matrix      (term_matrix),
      .term_vector      (term_vector),
      .term_take        (term_take)
   );

   mdpa_engine #(.WORD_BITS(WORD_BITS)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .modulus       (modulus_ff),
      .term_ctl      (term_ctl),
      .term_matrix   (term_matrix),
      .term_vector   (term_vector),
      .term_take     (term_take),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_dot_value (rsp_dot_value)
   );

endmodule

`default_nettype wire

[design/mdpa_front.sv]
// Front end: accepts requests and queues terms for the engine.
// Depends on mdpa_pkg.
`default_nettype none

module mdpa_front #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [WORD_BITS-1:0]   req_matrix_entry,
   input  wire logic [WORD_BITS-1:0]   req_vector_entry,
   input  wire logic                   req_last_term,
   output mdpa_pkg::term_ctl_type      term_ctl,
   output logic [WORD_BITS-1:0]        term_matrix,
   output logic [WORD_BITS-1:0]        term_vector,
   input  wire logic                   term_take
);
   import mdpa_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WORD_BITS-1:0] matrix_ff [QUEUE_DEPTH];
   logic [WORD_BITS-1:0] vector_ff [QUEUE_DEPTH];
   logic                 last_ff   [QUEUE_DEPTH];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 do_push, do_pop;

   // Queue status and head of queue.
   assign req_full            = (count_ff == CW'(QUEUE_DEPTH));
   assign do_push             = req_push && !req_full;
   assign term_ctl            = '{valid: (count_ff != '0), last_term: last_ff[rd_ptr_ff]};
   assign term_matrix         = matrix_ff[rd_ptr_ff];
   assign term_vector         = vector_ff[rd_ptr_ff];
   assign do_pop              = term_take && term_ctl.valid;

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Term storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         matrix_ff[wr_ptr_ff] <= req_matrix_entry;
         vector_ff[wr_ptr_ff] <= req_vector_entry;
         last_ff[wr_ptr_ff]   <= req_last_term;
      end
   end

endmodule

`default_nettype wire

[design/mdpa_engine.sv]
// Back end: bit-serial modular reduction, multiply and accumulate,
// plus the result queue. Depends on mdpa_pkg.
`default_nettype none

module mdpa_engine #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [WORD_BITS-1:0]   modulus,
   input  wire mdpa_pkg::term_ctl_type term_ctl,
   input  wire logic [WORD_BITS-1:0]   term_matrix,
   input  wire logic [WORD_BITS-1:0]   term_vector,
   output logic                        term_take,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [WORD_BITS-1:0]        rsp_dot_value
);
   import mdpa_pkg::*;

   localparam int BW = $clog2(WORD_BITS);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   engine_state_type     state_ff, state_in;
   logic [BW-1:0]        bit_ff, bit_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic                 last_ff, last_in;
   logic [WORD_BITS-1:0] ra_ff, ra_in;
   logic [WORD_BITS-1:0] rs_ff, rs_in;
   logic [WORD_BITS-1:0] prod_ff, prod_in;
   logic [WORD_BITS-1:0] sum_ff, sum_in;
   logic [WORD_BITS-1:0] mod_eff;
   logic [WORD_BITS-1:0] dbl, finish_value;
   logic                 res_push;

   logic [WORD_BITS-1:0] res_ff [QUEUE_DEPTH];
   logic                 res_wr_ff, res_rd_ff;
   logic [CW-1:0]        res_count_ff, res_count_in;
   logic                 res_full, res_pop;

   // Sum of two residues below m, reduced once.
   function automatic logic [WORD_BITS-1:0] mod_add(input logic [WORD_BITS-1:0] x,
                                                    input logic [WORD_BITS-1:0] y,
                                                    input logic [WORD_BITS-1:0] m);
      logic [WORD_BITS:0] t;
      t = {1'b0, x} + {1'b0, y};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[WORD_BITS-1:0];
   endfunction

   // One step of remainder by shifting in the next dividend bit.
   function automatic logic [WORD_BITS-1:0] mod_shift(input logic [WORD_BITS-1:0] r,
                                                      input logic             b,
                                                      input logic [WORD_BITS-1:0] m);
      logic [WORD_BITS:0] t;
      t = {r, b};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[WORD_BITS-1:0];
   endfunction

   // Modulus zero behaves as modulus one.
   assign mod_eff = (modulus == '0) ? WORD_BITS'(1) : modulus;

   assign dbl          = mod_add(prod_ff, prod_ff, mod_eff);
   assign finish_value = mod_add(rs_ff, prod_ff, mod_eff);
   assign res_full     = (res_count_ff == CW'(QUEUE_DEPTH));
   assign term_take    = (state_ff == ENG_IDLE);

   // Sequencer: reduce the sum and matrix entry, then double-and-add over
   // the vector entry, then accumulate or, on a last term, push the result.
   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      last_in  = last_ff;
      ra_in    = ra_ff;
      rs_in    = rs_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      res_push = 1'b0;
      case (state_ff)
         ENG_IDLE: begin
            if (term_ctl.valid) begin
               a_in     = term_matrix;
               b_in     = term_vector;
               last_in  = term_ctl.last_term;
               ra_in    = '0;
               rs_in    = '0;
               bit_in   = BW'(WORD_BITS - 1);
               state_in = ENG_REDUCE;
            end
         end
         ENG_REDUCE: begin
            ra_in = mod_shift(ra_ff, a_ff[bit_ff], mod_eff);
            rs_in = mod_shift(rs_ff, sum_ff[bit_ff], mod_eff);
            if (bit_ff == '0) begin
               bit_in   = BW'(WORD_BITS - 1);
               prod_in  = '0;
               state_in = ENG_MULTIPLY;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
         ENG_MULTIPLY: begin
            prod_in = b_ff[bit_ff] ? mod_add(dbl, ra_ff, mod_eff) : dbl;
            if (bit_ff == '0) begin
               state_in = ENG_FINISH;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
         ENG_FINISH: begin
            if (!last_ff) begin
               sum_in   = finish_value;
               state_in = ENG_IDLE;
            end else if (!res_full) begin
               res_push = 1'b1;
               sum_in   = '0;
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      last_ff <= last_in;
      ra_ff   <= ra_in;
      rs_ff   <= rs_in;
      prod_ff <= prod_in;
   end

   // Result queue.
   assign rsp_empty     = (res_count_ff == '0);
   assign rsp_dot_value = res_ff[res_rd_ff];
   assign res_pop       = rsp_pop && !rsp_empty;

   always_comb begin
      res_count_in = res_count_ff;
      if (res_push && !res_pop) begin
         res_count_in = res_count_ff + CW'(1);
      end else if (res_pop && !res_push) begin
         res_count_in = res_count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff    <= 1'b0;
         res_rd_ff    <= 1'b0;
         res_count_ff <= '0;
      end else begin
         res_wr_ff    <= res_push ? ~res_wr_ff : res_wr_ff;
         res_rd_ff    <= res_pop ? ~res_rd_ff : res_rd_ff;
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_ff[res_wr_ff] <= finish_value;
      end
   end

endmodule

`default_nettype wire

[bench/mdpa_checker.sv]
// Checker for the modular dot-product accumulator: watches the request, result
// and register ports, predicts every row result and compares. Depends on nothing.
// Hands its failure count and the number of outstanding results to the top.
module mdpa_checker #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  logic [WORD_BITS-1:0] req_matrix_entry,
   input  logic [WORD_BITS-1:0] req_vector_entry,
   input  logic                 req_last_term,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic [WORD_BITS-1:0] rsp_dot_value,
   input  logic                 csr_write,
   input  logic [WORD_BITS-1:0] csr_modulus,
   output int                   fail_count,
   output int                   rows_pending,
   output int                   rows_checked,
   output int                   terms_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [WORD_BITS-1:0] modulus_reg;
   logic [WORD_BITS-1:0] partial_sum;
   logic [WORD_BITS-1:0] row_results[$];

   initial begin
      fail_count = 0;
      rows_pending = 0;
      rows_checked = 0;
      terms_seen = 0;
      modulus_reg = 2;
      partial_sum = 0;
   end

   // Count a failure; only the first ten are shown.
   function automatic void note_failure(string what, logic [WORD_BITS-1:0] want,
                                        logic [WORD_BITS-1:0] got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
      end
   endfunction

   // Fold one accepted term into the running sum of its row.
   function automatic void accumulate_term(logic [WORD_BITS-1:0] mat,
                                           logic [WORD_BITS-1:0] vec, logic last);
      logic [63:0] m;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] s;
      m = (modulus_reg == 0) ? 64'd1 : 64'(modulus_reg);
      a = 64'(mat) % m;
      b = 64'(vec) % m;
      // The sum is reduced by the current modulus, which may have changed mid-row.
      s = 64'(partial_sum) % m;
      s = (s + (a * b) % m) % m;
      if (last) begin
         row_results.push_back(s[WORD_BITS-1:0]);
         partial_sum = 0;
      end else begin
         partial_sum = s[WORD_BITS-1:0];
      end
   endfunction

   // Track the channels at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         modulus_reg = 2;
         partial_sum = 0;
         row_results.delete();
      end else begin
         if (csr_write) begin
            modulus_reg = csr_modulus;
         end
         if (req_push && !req_full) begin
            terms_seen++;
            accumulate_term(req_matrix_entry, req_vector_entry, req_last_term);
         end
         if (rsp_pop && !rsp_empty) begin
            if (row_results.size() == 0) begin
               note_failure("result with none outstanding", 0, rsp_dot_value);
            end else begin
               logic [WORD_BITS-1:0] want;
               want = row_results.pop_front();
               rows_checked++;
               if (want !== rsp_dot_value) begin
                  note_failure("dot_value mismatch", want, rsp_dot_value);
               end
            end
         end
      end
      rows_pending = row_results.size();
   end
endmodule

[bench/testbench.sv]
// Top of the bench for the modular dot-product accumulator: clock, reset,
// request and register stimulus, result popping and verdict. Depends on the
// block's RTL and on mdpa_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WB = 32;
   localparam logic [WB-1:0] ALL_ONES = '1;
   // Three terms can be in flight.
   localparam int DRAIN_CYCLES = 300;
   localparam int TARGET_TERMS = 1400;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_push = 0;
   logic          req_full;
   logic [WB-1:0] req_matrix_entry = 0;
   logic [WB-1:0] req_vector_entry = 0;
   logic          req_last_term = 0;
   logic          rsp_empty;
   logic          rsp_pop = 0;
   logic [WB-1:0] rsp_dot_value;
   logic          csr_write = 0;
   logic [WB-1:0] csr_modulus = 0;

   int fail_count;
   int rows_pending;
   int rows_checked;
   int terms_seen;
   int terms_sent = 0;
   int modulus_settings = 0;
   int burst_left = 0;
   logic [WB-1:0] modulus_now = 2;

   modular_dot_product_accumulator #(.WORD_BITS(WB)) DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_matrix_entry(req_matrix_entry), .req_vector_entry(req_vector_entry),
      .req_last_term(req_last_term),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_dot_value(rsp_dot_value),
      .csr_write(csr_write), .csr_modulus(csr_modulus)
   );

   mdpa_checker #(.WORD_BITS(WB)) u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_matrix_entry(req_matrix_entry), .req_vector_entry(req_vector_entry),
      .req_last_term(req_last_term),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_dot_value(rsp_dot_value),
      .csr_write(csr_write), .csr_modulus(csr_modulus),
      .fail_count(fail_count), .rows_pending(rows_pending),
      .rows_checked(rows_checked), .terms_seen(terms_seen)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Hard stop for a hung run.
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offer one request and hold it until accepted; most bursts end in random gaps.
   task automatic send_term(logic [WB-1:0] mat, logic [WB-1:0] vec, logic last);
      @(negedge clock);
      req_push <= 1;
      req_matrix_entry <= mat;
      req_vector_entry <= vec;
      req_last_term <= last;
      do @(posedge clock); while (req_full);
      terms_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            req_push <= 0;
            repeat ($urandom_range(0, 20)) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Write the modulus once every expected row is back and the engine is quiet.
   task automatic set_modulus(logic [WB-1:0] value);
      @(negedge clock);
      req_push <= 0;
      while (rows_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write <= 1;
      csr_modulus <= value;
      @(negedge clock);
      csr_write <= 0;
      modulus_now = value;
      modulus_settings++;
   endtask

   // Operand mix: raw words, extremes, and values around the modulus.
   function automatic logic [WB-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return ALL_ONES;
         2: return modulus_now;
         3: return modulus_now - 1;
         4: return (modulus_now == 0) ? $urandom() : $urandom() % modulus_now;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WB-1:0] pick_modulus();
      case ($urandom_range(0, 6))
         0: return 2;
         1: return ALL_ONES;
         2: return 32'hFFFF_FFFB;
         3: return $urandom_range(2, 40);
         4: return $urandom() | 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   // Result side: changing pop patterns, with one long hold-off to fill the block.
   initial begin
      int mode;
      bit held;
      mode = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (!held && rows_checked >= 50) begin
            held = 1;
            rsp_pop <= 0;
            repeat (3000) @(negedge clock);
         end else begin
            if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
            case (mode)
               0: rsp_pop <= 1;
               1: rsp_pop <= $urandom_range(0, 1);
               default: rsp_pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Request stimulus and verdict.
   initial begin
      int row_len;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Reset modulus of two, extremes of the operands.
      send_term(ALL_ONES, ALL_ONES, 0);
      send_term(0, ALL_ONES, 0);
      send_term(32'h5555_5555, 32'hAAAA_AAAA, 1);
      // Largest modulus, operands at and just below it.
      set_modulus(ALL_ONES);
      send_term(ALL_ONES, ALL_ONES, 0);
      send_term(ALL_ONES - 1, ALL_ONES - 1, 0);
      send_term(ALL_ONES - 1, 32'h8000_0000, 1);
      send_term(32'hAAAA_AAAA, 32'h5555_5555, 1);
      // Modulus zero and one both give zero.
      set_modulus(0);
      send_term(ALL_ONES, 32'h1234_5678, 0);
      send_term(7, 9, 1);
      set_modulus(1);
      send_term(ALL_ONES, ALL_ONES, 0);
      send_term(3, 5, 1);
      // Modulus changed in the middle of a row.
      set_modulus(32'hFFFF_FFFB);
      send_term(32'hFFFF_FFFA, 32'hFFFF_FFFA, 0);
      send_term(ALL_ONES, 32'hFFFF_FFFB, 0);
      set_modulus(7);
      send_term(10, 13, 0);
      send_term(7, 1, 1);
      set_modulus(2);
      send_term(1, 1, 1);
      send_term(0, 0, 1);

      // Random rows, with a new modulus every so often, sometimes mid-row.
      while (terms_sent < TARGET_TERMS) begin
         if ($urandom_range(0, 9) == 0) set_modulus(pick_modulus());
         row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                              : $urandom_range(1, 6);
         for (int k = 0; k < row_len; k++) begin
            send_term(pick_operand(), pick_operand(),
                      (k == row_len - 1) && ($urandom_range(0, 19) != 0));
         end
      end
      send_term(pick_operand(), pick_operand(), 1);

      @(negedge clock);
      req_push <= 0;
      while (rows_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d terms and %0d row results under %0d modulus settings.",
               terms_seen, rows_checked, modulus_settings);
      if (fail_count == 0 && rows_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

[files.f]
design/mdpa_pkg.sv
design/mdpa_front.sv
design/mdpa_engine.sv
design/modular_dot_product_accumulator.sv
bench/mdpa_checker.sv
bench/testbench.sv
